/* hdl/ipt_pkg.sv */
// ---------------------------------------------------------------------------
// ipt_pkg
// Shared types, constants and helpers of the IP traffic counter table.
// ---------------------------------------------------------------------------
package ipt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned HASH_SLOTS_DEF  = 2048;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned RIDX_W      = 10;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned CNT64_W     = 64;
  localparam int unsigned INTERVAL_W  = 32;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd1000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_ZERO_AS = 32'd1000;
  localparam logic [31:0] HASH_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] HASH_C2 = 32'hc2b2_ae35;

  localparam logic [FUNC_W-1:0] FUNC_REPORT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;

  localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLOSED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd6;

  typedef struct packed {
    logic              is_v6;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic [63:0]       last_up;
    logic [63:0]       last_dn;
    logic [63:0]       rate_up;
    logic [63:0]       rate_dn;
    logic [63:0]       tot_up;
    logic [63:0]       tot_dn;
    logic              seen_up;
    logic              seen_dn;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   entry_index;
    logic                entry_valid;
    logic                entry_is_v6;
    logic [ADDR_W-1:0]   entry_addr_hi;
    logic [ADDR_W-1:0]   entry_addr_lo;
    logic [63:0]         up_rate;
    logic [63:0]         dn_rate;
    logic [63:0]         up_bytes;
    logic [63:0]         dn_bytes;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic res_t entry_res(input logic [STATUS_W-1:0] st,
                                     input logic [RIDX_W-1:0] idx,
                                     input entry_t e);
    res_t r;
    r.status        = st;
    r.entry_index   = idx;
    r.entry_valid   = 1'b1;
    r.entry_is_v6   = e.is_v6;
    r.entry_addr_hi = e.addr_hi;
    r.entry_addr_lo = e.addr_lo;
    r.up_rate       = e.rate_up;
    r.dn_rate       = e.rate_dn;
    r.up_bytes      = e.tot_up;
    r.dn_bytes      = e.tot_dn;
    entry_res = r;
  endfunction

endpackage

/* hdl/ipt_in_if.sv */
// ---------------------------------------------------------------------------
// ipt_in_if
// Request channel: function code, address, direction and byte counter.
// ---------------------------------------------------------------------------
interface ipt_in_if import ipt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic                  is_v6;
  logic [ADDR_W-1:0]     addr_hi;
  logic [ADDR_W-1:0]     addr_lo;
  logic                  dir_dn;
  logic [CNT64_W-1:0]    byte_count;
  logic [RIDX_W-1:0]     read_index;

  modport source (output valid, func, is_v6, addr_hi, addr_lo, dir_dn, byte_count,
                  read_index, input ready);
  modport sink   (input valid, func, is_v6, addr_hi, addr_lo, dir_dn, byte_count,
                  read_index, output ready);
endinterface

/* hdl/ipt_out_if.sv */
// ---------------------------------------------------------------------------
// ipt_out_if
// Result channel: status and the entry touched or read.
// ---------------------------------------------------------------------------
interface ipt_out_if import ipt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RIDX_W-1:0]   entry_index;
  logic                entry_valid;
  logic                entry_is_v6;
  logic [ADDR_W-1:0]   entry_addr_hi;
  logic [ADDR_W-1:0]   entry_addr_lo;
  logic [63:0]         up_rate;
  logic [63:0]         dn_rate;
  logic [63:0]         up_bytes;
  logic [63:0]         dn_bytes;

  modport source (output valid, status, entry_index, entry_valid, entry_is_v6, entry_addr_hi,
                  entry_addr_lo, up_rate, dn_rate, up_bytes, dn_bytes, input ready);
  modport sink   (input valid, status, entry_index, entry_valid, entry_is_v6, entry_addr_hi,
                  entry_addr_lo, up_rate, dn_rate, up_bytes, dn_bytes, output ready);
endinterface

/* hdl/ipt_cfg_if.sv */
// ---------------------------------------------------------------------------
// ipt_cfg_if
// Configuration write channel for the poll interval register.
// ---------------------------------------------------------------------------
interface ipt_cfg_if import ipt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [INTERVAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hdl/ipt_ram.sv */
// ---------------------------------------------------------------------------
// ipt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ipt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ipt_div.sv */
// ---------------------------------------------------------------------------
// ipt_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module ipt_div import ipt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  always_comb begin
    shifted = {rem_q, quo_q[63]};
    diff    = shifted - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* hdl/ip_traffic_counter_table.sv */
// ---------------------------------------------------------------------------
// ip_traffic_counter_table
// Per-host byte counter table with hashed, linearly probed lookup.
// ---------------------------------------------------------------------------
// One request at a time. A counter report hashes its address, probes the slot
// table from the home slot, runs the rate division on the bit-serial divider,
// then updates the entry, writes it back and presents the result. Each further
// occupied slot probed adds a probe step, a new host skips the entry read, and a
// report whose stored last counter for its direction is zero skips the division.
// Close round reads and rewrites each stored entry in turn, a read fetches one
// entry, and clear table wipes one hash slot per cycle. After reset the slot
// memory is swept once before the first request is taken. HASH_SLOTS must be a
// power of two. A result may sit in the output register while the next request
// is being worked on.
module ip_traffic_counter_table import ipt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned HASH_SLOTS  = HASH_SLOTS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ipt_in_if.sink   in_i,
  ipt_out_if.source out_o,
  ipt_cfg_if.sink  cfg_i
);

  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SLOT_W = $clog2(HASH_SLOTS);
  localparam int unsigned ENT_W  = $bits(entry_t);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_HA   = 5'd2;
  localparam logic [4:0] S_HB   = 5'd3;
  localparam logic [4:0] S_HC   = 5'd4;
  localparam logic [4:0] S_P0   = 5'd6;
  localparam logic [4:0] S_P1   = 5'd7;
  localparam logic [4:0] S_P2   = 5'd8;
  localparam logic [4:0] S_UPD  = 5'd9;
  localparam logic [4:0] S_DS   = 5'd10;
  localparam logic [4:0] S_DIV  = 5'd11;
  localparam logic [4:0] S_WB   = 5'd12;
  localparam logic [4:0] S_C0   = 5'd13;
  localparam logic [4:0] S_C1   = 5'd14;
  localparam logic [4:0] S_R1   = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HASH_SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ENTRIES);

  logic [4:0]            state_q, state_d;
  logic [INTERVAL_W-1:0] interval_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SLOT_W-1:0]     clr_q, clr_d;
  logic                  post_q, post_d;
  logic [SLOT_W-1:0]     pos_q, pos_d;
  logic [SLOT_W-1:0]     probe_q, probe_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      ci_q, ci_d;
  logic                  found_q, found_d;
  logic [31:0]           hash_q, hash_d;
  logic [63:0]           prod_q, prod_d;
  entry_t                rec_q, rec_d;
  res_t                  res_q, res_d;
  res_t                  out_q;
  logic                  out_valid_q, out_valid_d;

  logic                  v6_q, dir_q;
  logic [ADDR_W-1:0]     hi_q, lo_q;
  logic [63:0]           bytes_q;

  logic                  in_acc;
  logic [ADDR_W-1:0]     key_hi, key_lo;
  logic [31:0]           key_x, key_s;
  logic [31:0]           hmix;
  logic [31:0]           hfin;
  logic [63:0]           last_sel, delta;
  entry_t                ent_rd, ent_wr;

  logic                  s_we, s_re;
  logic [SLOT_W-1:0]     s_waddr, s_raddr;
  logic [CNT_W-1:0]      s_wdata, s_rdata;
  logic                  e_we, e_re;
  logic [IDX_W-1:0]      e_waddr, e_raddr;
  logic [ENT_W-1:0]      e_rdata;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  ipt_ram #(.WIDTH(CNT_W), .DEPTH(HASH_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  ipt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (ent_wr),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  ipt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign ent_rd      = entry_t'(e_rdata);
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    key_hi = in_i.is_v6 ? in_i.addr_hi : '0;
    key_lo = in_i.is_v6 ? in_i.addr_lo : {32'd0, in_i.addr_lo[31:0]};
    key_x  = key_lo[31:0] ^ key_lo[63:32] ^ key_hi[31:0] ^ key_hi[63:32];
    key_s  = swap32(key_x);
    hmix   = hash_q ^ (hash_q >> 13);
    hfin   = hash_q ^ (hash_q >> 16);
    last_sel = dir_q ? rec_q.last_dn : rec_q.last_up;
    delta    = (bytes_q >= last_sel) ? (bytes_q - last_sel) : bytes_q;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    clr_d       = clr_q;
    post_d      = post_q;
    pos_d       = pos_q;
    probe_d     = probe_q;
    idx_d       = idx_q;
    ci_d        = ci_q;
    found_d     = found_q;
    hash_d      = hash_q;
    prod_d      = prod_q;
    rec_d       = rec_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    s_we = 1'b0; s_waddr = clr_q; s_wdata = '0;
    s_re = 1'b0; s_raddr = pos_q;
    e_we = 1'b0; e_waddr = idx_q; ent_wr = rec_q;
    e_re = 1'b0; e_raddr = idx_q;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = (interval_q == '0) ? INTERVAL_ZERO_AS : interval_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          case (in_i.func)
            FUNC_REPORT: begin
              hash_d  = key_s ^ (key_s >> 16);
              state_d = S_HA;
            end
            FUNC_CLOSE: begin
              res_d.status = ST_CLOSED;
              ci_d         = '0;
              state_d      = (count_q == '0) ? S_DONE : S_C0;
            end
            FUNC_READ: begin
              res_d.status      = ST_READ;
              res_d.entry_index = in_i.read_index;
              if (32'(in_i.read_index) < 32'(count_q)) begin
                e_re    = 1'b1;
                e_raddr = IDX_W'(in_i.read_index);
                state_d = S_R1;
              end else begin
                state_d = S_DONE;
              end
            end
            FUNC_CLEAR: begin
              res_d.status = ST_CLEARED;
              count_d      = '0;
              clr_d        = '0;
              post_d       = 1'b1;
              state_d      = S_CLR;
            end
            default: begin
              res_d.status = ST_IDLE;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        s_we    = 1'b1;
        s_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == SLOT_LAST) begin
          state_d = post_q ? S_DONE : S_IDLE;
        end
      end
      S_HA: begin
        hash_d  = hash_q * HASH_C1;
        state_d = S_HB;
      end
      S_HB: begin
        hash_d  = hmix * HASH_C2;
        state_d = S_HC;
      end
      S_HC: begin
        pos_d   = SLOT_W'(hfin);
        probe_d = '0;
        state_d = S_P0;
      end
      S_P0: begin
        s_re    = 1'b1;
        s_raddr = pos_q;
        state_d = S_P1;
      end
      S_P1: begin
        if (s_rdata == '0) begin
          if (count_q >= CNT_MAX) begin
            res_d        = '0;
            res_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            s_we          = 1'b1;
            s_waddr       = pos_q;
            s_wdata       = count_q + 1'b1;
            idx_d         = IDX_W'(count_q);
            count_d       = count_q + 1'b1;
            rec_d         = '0;
            rec_d.is_v6   = v6_q;
            rec_d.addr_hi = hi_q;
            rec_d.addr_lo = lo_q;
            found_d       = 1'b0;
            state_d       = S_UPD;
          end
        end else begin
          e_re    = 1'b1;
          e_raddr = IDX_W'(s_rdata - 1'b1);
          idx_d   = IDX_W'(s_rdata - 1'b1);
          state_d = S_P2;
        end
      end
      S_P2: begin
        if (ent_rd.is_v6 == v6_q && ent_rd.addr_hi == hi_q && ent_rd.addr_lo == lo_q) begin
          rec_d   = ent_rd;
          found_d = 1'b1;
          state_d = S_UPD;
        end else if (probe_q == SLOT_LAST) begin
          res_d        = '0;
          res_d.status = ST_FULL;
          state_d      = S_DONE;
        end else begin
          probe_d = probe_q + 1'b1;
          pos_d   = (pos_q == SLOT_LAST) ? '0 : pos_q + 1'b1;
          state_d = S_P0;
        end
      end
      S_UPD: begin
        if (dir_q) begin
          rec_d.seen_dn = 1'b1;
          rec_d.last_dn = bytes_q;
        end else begin
          rec_d.seen_up = 1'b1;
          rec_d.last_up = bytes_q;
        end
        if (last_sel == '0) begin
          if (dir_q) begin
            rec_d.rate_dn = '0;
          end else begin
            rec_d.rate_up = '0;
          end
          state_d = S_WB;
        end else begin
          if (dir_q) begin
            rec_d.tot_dn = rec_q.tot_dn + delta;
          end else begin
            rec_d.tot_up = rec_q.tot_up + delta;
          end
          prod_d  = (delta << 10) - (delta << 4) - (delta << 3);
          state_d = S_DS;
        end
      end
      S_DS: begin
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (dir_q) begin
            rec_d.rate_dn = div_rsp.quotient;
          end else begin
            rec_d.rate_up = div_rsp.quotient;
          end
          state_d = S_WB;
        end
      end
      S_WB: begin
        e_we    = 1'b1;
        e_waddr = idx_q;
        ent_wr  = rec_q;
        res_d   = entry_res(found_q ? ST_UPDATED : ST_ADDED, RIDX_W'(idx_q), rec_q);
        state_d = S_DONE;
      end
      S_C0: begin
        e_re    = 1'b1;
        e_raddr = IDX_W'(ci_q);
        state_d = S_C1;
      end
      S_C1: begin
        ent_wr = ent_rd;
        if (!ent_rd.seen_up) begin
          ent_wr.rate_up = '0;
        end
        if (!ent_rd.seen_dn) begin
          ent_wr.rate_dn = '0;
        end
        ent_wr.seen_up = 1'b0;
        ent_wr.seen_dn = 1'b0;
        e_we    = 1'b1;
        e_waddr = IDX_W'(ci_q);
        ci_d    = ci_q + 1'b1;
        state_d = (ci_q + 1'b1 == count_q) ? S_DONE : S_C0;
      end
      S_R1: begin
        res_d   = entry_res(ST_READ, res_q.entry_index, ent_rd);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      interval_q  <= INTERVAL_RESET;
      count_q     <= '0;
      clr_q       <= '0;
      post_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      post_q      <= post_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        interval_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    probe_q <= probe_d;
    idx_q   <= idx_d;
    ci_q    <= ci_d;
    found_q <= found_d;
    hash_q  <= hash_d;
    prod_q  <= prod_d;
    rec_q   <= rec_d;
    res_q   <= res_d;
    if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
      out_q <= res_q;
    end
    if (in_acc) begin
      v6_q    <= in_i.is_v6;
      dir_q   <= in_i.dir_dn;
      hi_q    <= key_hi;
      lo_q    <= key_lo;
      bytes_q <= in_i.byte_count;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.entry_index   = out_q.entry_index;
  assign out_o.entry_valid   = out_q.entry_valid;
  assign out_o.entry_is_v6   = out_q.entry_is_v6;
  assign out_o.entry_addr_hi = out_q.entry_addr_hi;
  assign out_o.entry_addr_lo = out_q.entry_addr_lo;
  assign out_o.up_rate       = out_q.up_rate;
  assign out_o.dn_rate       = out_q.dn_rate;
  assign out_o.up_bytes      = out_q.up_bytes;
  assign out_o.dn_bytes      = out_q.dn_bytes;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("entry count above table size");

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("request accepted but no work started");

  a_div_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside a wait state");

endmodule
